// ----- design/pcab_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pcab_pkg
// shared constants and codes for the point-to-cell adjacency builder
// ----------------------------------------------------------------------------
package pcab_pkg;

	// default sizes of the table
	localparam int MAX_POINTS_DEF      = 1024;
	localparam int SLOTS_PER_POINT_DEF = 16;

	// stored label width, equal to the cell_label port width
	localparam int LABEL_W = 16;

	// port widths fixed by the interface
	localparam int CMD_W    = 2;
	localparam int POINT_W  = 10;
	localparam int SLOT_W   = 4;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	// command codes
	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_READ   = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	// status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_ADDED   = 2'd0,
		ST_PRESENT = 2'd1,
		ST_FULL    = 2'd2,
		ST_DONE    = 2'd3
	} status_t;

endpackage
`default_nettype wire

// ----- design/point_cell_adjacency_builder_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// point_cell_adjacency_builder_core
// point-to-cell inverse adjacency table with de-duplicating insert
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; its single result
// appears on status, cell_count, cell_out and slot_valid for one cycle with
// done high, and the receiver cannot stall it. After reset the block clears
// its per-point counts, one point a cycle, and busy stays high until the
// last point is cleared. An insert fetches the point's count, then walks the
// stored labels through one comparator, one slot read per cycle from the
// label memory, and ends the walk early on a hit. A read fetches the count
// and then, for a stored slot, its label; a clear, an unused command or a
// read past the count finishes after the count fetch, and an out-of-range
// point is answered from idle. busy is low in the cycle that done is high,
// so the next word may be taken then.
module point_cell_adjacency_builder_core #(
	parameter int MAX_POINTS      = pcab_pkg::MAX_POINTS_DEF,
	parameter int SLOTS_PER_POINT = pcab_pkg::SLOTS_PER_POINT_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [pcab_pkg::CMD_W-1:0]    command,
	input  wire logic [pcab_pkg::POINT_W-1:0]  point_index,
	input  wire logic [pcab_pkg::LABEL_W-1:0]  cell_label,
	input  wire logic [pcab_pkg::SLOT_W-1:0]   slot,
	output logic                               done,
	output logic [pcab_pkg::STATUS_W-1:0]      status,
	output logic [pcab_pkg::COUNT_W-1:0]       cell_count,
	output logic [pcab_pkg::LABEL_W-1:0]       cell_out,
	output logic                               slot_valid
);

	localparam int PW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW    = $clog2(SLOTS_PER_POINT + 1);
	localparam int DEPTH = MAX_POINTS * SLOTS_PER_POINT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW-1:0] SLOTS_A = AW'(SLOTS_PER_POINT);
	localparam logic [PW-1:0] LAST_PT = PW'(MAX_POINTS - 1);

	typedef enum logic [5:0] {
		S_INIT   = 6'b000001,
		S_IDLE   = 6'b000010,
		S_CNT    = 6'b000100,
		S_SCAN   = 6'b001000,
		S_RDWAIT = 6'b010000,
		S_SPARE  = 6'b100000
	} state_t;

	state_t                      state_q, state_d;
	logic                        accept;
	logic                        pt_oor;

	// latched word
	pcab_pkg::cmd_t              cmd_q;
	logic [PW-1:0]               pt_q;
	logic [pcab_pkg::LABEL_W-1:0] label_q;
	logic [pcab_pkg::SLOT_W-1:0] slot_q;
	logic [AW-1:0]               base_q;

	// scan control
	logic [CW-1:0]               idx_q, idx_d;
	logic                        data_vld_q, data_vld_d;
	logic [PW-1:0]               clr_idx_q;
	logic                        hit;

	// count memory
	logic [CW-1:0]               cnt_mem [MAX_POINTS];
	logic [CW-1:0]               cnt_rd_q;
	logic                        cnt_we;
	logic [PW-1:0]               cnt_wa;
	logic [CW-1:0]               cnt_wd;
	logic [CW-1:0]               cnt_inc;

	// label memory
	logic [pcab_pkg::LABEL_W-1:0] st_mem [DEPTH];
	logic [pcab_pkg::LABEL_W-1:0] st_rd_q;
	logic                        st_we, st_re;
	logic [CW-1:0]               st_off;
	logic [AW-1:0]               st_addr;

	// result staging
	logic                        resp_set;
	pcab_pkg::status_t           resp_status;
	logic [pcab_pkg::COUNT_W-1:0] resp_count;
	logic [pcab_pkg::LABEL_W-1:0] resp_cell;
	logic                        resp_valid;

	assign busy    = (state_q != S_IDLE);
	assign accept  = start && !busy;
	assign pt_oor  = (32'(point_index) >= 32'(MAX_POINTS));
	assign hit     = data_vld_q && (st_rd_q == label_q);
	assign cnt_inc = CW'(cnt_rd_q + CW'(1));
	assign st_addr = base_q + AW'(st_off);

	// sequencer
	always_comb begin
		state_d     = state_q;
		idx_d       = idx_q;
		data_vld_d  = data_vld_q;
		cnt_we      = 1'b0;
		cnt_wa      = pt_q;
		cnt_wd      = '0;
		st_we       = 1'b0;
		st_re       = 1'b0;
		st_off      = idx_q;
		resp_set    = 1'b0;
		resp_status = pcab_pkg::ST_DONE;
		resp_count  = '0;
		resp_cell   = '0;
		resp_valid  = 1'b0;
		unique case (state_q)
			S_INIT: begin
				cnt_we = 1'b1;
				cnt_wa = clr_idx_q;
				if (clr_idx_q == LAST_PT) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					if (pt_oor) begin
						resp_set    = 1'b1;
						resp_status = (pcab_pkg::cmd_t'(command) == pcab_pkg::CMD_INSERT)
							? pcab_pkg::ST_FULL : pcab_pkg::ST_DONE;
					end else begin
						state_d = S_CNT;
					end
				end
			end
			S_CNT: begin
				unique case (cmd_q)
					pcab_pkg::CMD_INSERT: begin
						idx_d      = '0;
						data_vld_d = 1'b0;
						state_d    = S_SCAN;
					end
					pcab_pkg::CMD_READ: begin
						if (32'(slot_q) < 32'(cnt_rd_q) &&
						    32'(slot_q) < 32'(SLOTS_PER_POINT)) begin
							st_re   = 1'b1;
							st_off  = CW'(slot_q);
							state_d = S_RDWAIT;
						end else begin
							resp_set   = 1'b1;
							resp_count = pcab_pkg::COUNT_W'(cnt_rd_q);
							state_d    = S_IDLE;
						end
					end
					pcab_pkg::CMD_CLEAR: begin
						cnt_we   = 1'b1;
						resp_set = 1'b1;
						state_d  = S_IDLE;
					end
					pcab_pkg::CMD_NONE: begin
						resp_set   = 1'b1;
						resp_count = pcab_pkg::COUNT_W'(cnt_rd_q);
						state_d    = S_IDLE;
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_SCAN: begin
				// compare the slot fetched last cycle while fetching the next
				priority if (hit) begin
					resp_set    = 1'b1;
					resp_status = pcab_pkg::ST_PRESENT;
					resp_count  = pcab_pkg::COUNT_W'(cnt_rd_q);
					state_d     = S_IDLE;
				end else if (idx_q < cnt_rd_q && 32'(idx_q) < 32'(SLOTS_PER_POINT)) begin
					st_re      = 1'b1;
					idx_d      = CW'(idx_q + CW'(1));
					data_vld_d = 1'b1;
				end else if (data_vld_q) begin
					data_vld_d = 1'b0;
				end else if (32'(cnt_rd_q) >= 32'(SLOTS_PER_POINT)) begin
					resp_set    = 1'b1;
					resp_status = pcab_pkg::ST_FULL;
					resp_count  = pcab_pkg::COUNT_W'(cnt_rd_q);
					state_d     = S_IDLE;
				end else begin
					// append at the end of the list
					st_we       = 1'b1;
					st_off      = cnt_rd_q;
					cnt_we      = 1'b1;
					cnt_wd      = cnt_inc;
					resp_set    = 1'b1;
					resp_status = pcab_pkg::ST_ADDED;
					resp_count  = pcab_pkg::COUNT_W'(cnt_inc);
					state_d     = S_IDLE;
				end
			end
			S_RDWAIT: begin
				resp_set   = 1'b1;
				resp_count = pcab_pkg::COUNT_W'(cnt_rd_q);
				resp_cell  = st_rd_q;
				resp_valid = 1'b1;
				state_d    = S_IDLE;
			end
			S_SPARE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_INIT;
			clr_idx_q  <= '0;
			idx_q      <= '0;
			data_vld_q <= 1'b0;
			done       <= 1'b0;
		end else begin
			state_q    <= state_d;
			idx_q      <= idx_d;
			data_vld_q <= data_vld_d;
			done       <= resp_set;
			if (state_q == S_INIT) begin
				clr_idx_q <= PW'(clr_idx_q + PW'(1));
			end
		end
	end

	// word capture and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= pcab_pkg::cmd_t'(command);
			pt_q    <= PW'(point_index);
			label_q <= cell_label;
			slot_q  <= slot;
			base_q  <= AW'(AW'(point_index) * SLOTS_A);
		end
		if (resp_set) begin
			status     <= resp_status;
			cell_count <= resp_count;
			cell_out   <= resp_cell;
			slot_valid <= resp_valid;
		end
	end

	// per-point count memory
	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_wa] <= cnt_wd;
		end
		if (accept) begin
			cnt_rd_q <= cnt_mem[PW'(point_index)];
		end
	end

	// label memory
	always_ff @(posedge clk) begin
		if (st_we) begin
			st_mem[st_addr] <= label_q;
		end
		if (st_re) begin
			st_rd_q <= st_mem[st_addr];
		end
	end

	// checks
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while sequencer busy");

	a_append_room: assert property (@(posedge clk) disable iff (!arst_n)
		st_we |-> (32'(cnt_rd_q) < 32'(SLOTS_PER_POINT)))
		else $error("append into a full list");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (idx_q <= cnt_rd_q))
		else $error("scan index beyond count");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done || $past(accept))
		else $error("back-to-back results without a new word");

endmodule
`default_nettype wire
